>>> sv/reflow_profile_sequencer_assert.svh
// assertion macros for the reflow profile sequencer checker
// no dependencies; taken in by include where assertions are written
`ifndef REFLOW_PROFILE_SEQUENCER_ASSERT_SVH
`define REFLOW_PROFILE_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rps_pkg.sv
// types and constants shared by the reflow profile sequencer
// no dependencies
`timescale 1ns / 1ps

package rps_pkg;

   localparam int TempW   = 11;
   localparam int LevelW  = 10;
   localparam int SecW    = 12;
   localparam int MsW     = 32;
   localparam int DurMsW  = 22;
   localparam int PhaseW  = 3;
   localparam int AddrW   = 5;
   localparam int DataW   = 32;

   localparam logic [LevelW-1:0] MS_PER_S = LevelW'(1000);

   // register indexes
   localparam logic [2:0] REG_SOAK_TEMP = 3'd0;
   localparam logic [2:0] REG_SOAK_SEC  = 3'd1;
   localparam logic [2:0] REG_PEAK_TEMP = 3'd2;
   localparam logic [2:0] REG_PEAK_SEC  = 3'd3;
   localparam logic [2:0] REG_COOL_TEMP = 3'd4;

   // register reset values
   localparam logic [LevelW-1:0] RST_SOAK_TEMP = LevelW'(150);
   localparam logic [SecW-1:0]   RST_SOAK_SEC  = SecW'(90);
   localparam logic [LevelW-1:0] RST_PEAK_TEMP = LevelW'(240);
   localparam logic [SecW-1:0]   RST_PEAK_SEC  = SecW'(60);
   localparam logic [LevelW-1:0] RST_COOL_TEMP = LevelW'(50);

   typedef enum logic [PhaseW-1:0] {
      PH_IDLE    = 3'd0,
      PH_PREHEAT = 3'd1,
      PH_SOAK    = 3'd2,
      PH_RAMP    = 3'd3,
      PH_REFLOW  = 3'd4,
      PH_COOL    = 3'd5
   } phase_type;

   typedef struct packed {
      logic [LevelW-1:0] preheat_end;
      logic [DurMsW-1:0] soak_ms;
      logic [LevelW-1:0] peak_temp;
      logic [DurMsW-1:0] peak_ms;
      logic [LevelW-1:0] cool_temp;
   } cfg_type;

   typedef struct packed {
      logic signed [TempW-1:0] temperature;
      logic                    run;
      logic [MsW-1:0]          now_ms;
   } item_type;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [LevelW-1:0] setpoint;
      logic              acted;
      logic              stopped;
   } result_type;

endpackage

>>> sv/rps_csr.sv
// configuration registers with apb-style access and precomputed durations in ms
// depends on rps_pkg
`timescale 1ns / 1ps

module rps_csr
   import rps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [AddrW-1:0] csr_paddr,
   input  logic [DataW-1:0] csr_pwdata,
   output logic [DataW-1:0] csr_prdata,
   output cfg_type          cfg
);

   logic [LevelW-1:0] preheat_end_ff, peak_temp_ff, cool_temp_ff;
   logic [SecW-1:0]   soak_sec_ff, peak_sec_ff;
   logic [DurMsW-1:0] soak_ms_ff, peak_ms_ff;
   logic              wr_en;
   logic [2:0]        index;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign index = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         preheat_end_ff <= RST_SOAK_TEMP;
         soak_sec_ff    <= RST_SOAK_SEC;
         peak_temp_ff   <= RST_PEAK_TEMP;
         peak_sec_ff    <= RST_PEAK_SEC;
         cool_temp_ff   <= RST_COOL_TEMP;
      end else if (wr_en) begin
         case (index)
            REG_SOAK_TEMP: preheat_end_ff <= csr_pwdata[LevelW-1:0];
            REG_SOAK_SEC:  soak_sec_ff    <= csr_pwdata[SecW-1:0];
            REG_PEAK_TEMP: peak_temp_ff   <= csr_pwdata[LevelW-1:0];
            REG_PEAK_SEC:  peak_sec_ff    <= csr_pwdata[SecW-1:0];
            REG_COOL_TEMP: cool_temp_ff   <= csr_pwdata[LevelW-1:0];
            default: ;
         endcase
      end
   end

   // durations in ms are registered products of the second counts
   always_ff @(posedge clock) begin
      soak_ms_ff <= DurMsW'(soak_sec_ff) * DurMsW'(MS_PER_S);
      peak_ms_ff <= DurMsW'(peak_sec_ff) * DurMsW'(MS_PER_S);
   end

   always_comb begin
      case (index)
         REG_SOAK_TEMP: csr_prdata = DataW'(preheat_end_ff);
         REG_SOAK_SEC:  csr_prdata = DataW'(soak_sec_ff);
         REG_PEAK_TEMP: csr_prdata = DataW'(peak_temp_ff);
         REG_PEAK_SEC:  csr_prdata = DataW'(peak_sec_ff);
         REG_COOL_TEMP: csr_prdata = DataW'(cool_temp_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.preheat_end = preheat_end_ff;
   assign cfg.soak_ms     = soak_ms_ff;
   assign cfg.peak_temp   = peak_temp_ff;
   assign cfg.peak_ms     = peak_ms_ff;
   assign cfg.cool_temp   = cool_temp_ff;

endmodule

>>> sv/rps_core.sv
// phase state machine: profile state registers and the per-item step logic
// depends on rps_pkg
`timescale 1ns / 1ps

module rps_core
   import rps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type         phase_ff, phase_in;
   logic [LevelW-1:0] ref_ff, ref_in;
   logic [MsW-1:0]    begin_ff, begin_in;
   logic              was_running_ff, was_running_in;
   logic [MsW-1:0]    elapsed;
   logic              soak_reached, peak_reached, cool_reached;
   logic              soak_done, peak_done;

   assign elapsed      = item.now_ms - begin_ff;
   assign soak_reached = item.temperature >= $signed({1'b0, cfg.preheat_end});
   assign peak_reached = item.temperature >= $signed({1'b0, cfg.peak_temp});
   assign cool_reached = item.temperature <= $signed({1'b0, cfg.cool_temp});
   assign soak_done    = elapsed >= MsW'(cfg.soak_ms);
   assign peak_done    = elapsed >= MsW'(cfg.peak_ms);

   // next state
   always_comb begin
      phase_in       = phase_ff;
      ref_in         = ref_ff;
      begin_in       = begin_ff;
      was_running_in = was_running_ff;
      if (item.run) begin
         was_running_in = 1'b1;
         case (phase_ff)
            PH_IDLE: phase_in = PH_PREHEAT;
            PH_PREHEAT: begin
               ref_in = cfg.preheat_end;
               if (soak_reached) begin
                  begin_in = item.now_ms;
                  phase_in = PH_SOAK;
               end
            end
            PH_SOAK: begin
               ref_in = cfg.preheat_end;
               if (soak_done) begin
                  begin_in = '0;
                  phase_in = PH_RAMP;
               end
            end
            PH_RAMP: begin
               ref_in = cfg.peak_temp;
               if (peak_reached) begin
                  begin_in = item.now_ms;
                  phase_in = PH_REFLOW;
               end
            end
            PH_REFLOW: begin
               ref_in = cfg.peak_temp;
               if (peak_done) begin
                  begin_in = '0;
                  phase_in = PH_COOL;
               end
            end
            PH_COOL: begin
               ref_in = cfg.cool_temp;
               if (cool_reached) begin
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end else if (was_running_ff) begin
         phase_in       = PH_IDLE;
         ref_in         = '0;
         was_running_in = 1'b0;
      end
   end

   // outputs
   always_comb begin
      result.phase    = phase_in;
      result.setpoint = ref_in;
      result.acted    = item.run || was_running_ff;
      result.stopped  = !item.run && was_running_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         ref_ff         <= '0;
         begin_ff       <= '0;
         was_running_ff <= 1'b1;
      end else if (step) begin
         phase_ff       <= phase_in;
         ref_ff         <= ref_in;
         begin_ff       <= begin_in;
         was_running_ff <= was_running_in;
      end
   end

endmodule

>>> sv/reflow_profile_sequencer.sv
// reflow profile sequencer top level: register block, input register, phase core, result register
// depends on rps_pkg, rps_csr, rps_core
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | temperature, run, now_ms
//  rsp     | out       | rsp_valid / rsp_stall | phase, setpoint, acted, stopped
//  csr     | in        | psel / penable        | paddr, pwdata, prdata
//
// an item is held in the input register from acceptance, and its result is stored in the result register;
// the phase step between them is combinational
// one item per cycle is sustained while rsp_stall stays low
// req_stall rises only when both registers hold items and rsp_stall is high
// reset restores the register defaults, idle phase and an empty pipeline

module reflow_profile_sequencer
   import rps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [TempW-1:0] req_temperature,
   input  logic                    req_run,
   input  logic [MsW-1:0]          req_now_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PhaseW-1:0]       rsp_phase,
   output logic [LevelW-1:0]       rsp_setpoint,
   output logic                    rsp_acted,
   output logic                    rsp_stopped,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [AddrW-1:0]        csr_paddr,
   input  logic [DataW-1:0]        csr_pwdata,
   output logic [DataW-1:0]        csr_prdata,
   output logic                    csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   result_type result, result_ff;
   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   logic       req_take, fire;

   assign csr_pready = 1'b1;

   rps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // held item moves on when the result register is empty or being drained
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   rps_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.temperature <= req_temperature;
         item_ff.run         <= req_run;
         item_ff.now_ms      <= req_now_ms;
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_phase    = result_ff.phase;
   assign rsp_setpoint = result_ff.setpoint;
   assign rsp_acted    = result_ff.acted;
   assign rsp_stopped  = result_ff.stopped;

endmodule

>>> sv/rps_checker.sv
// port-level checks for the reflow profile sequencer, bound to the top level
// depends on rps_pkg and reflow_profile_sequencer_assert.svh
`timescale 1ns / 1ps
`include "reflow_profile_sequencer_assert.svh"

module rps_checker
   import rps_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [PhaseW-1:0]       rsp_phase,
   input logic [LevelW-1:0]       rsp_setpoint,
   input logic                    rsp_acted,
   input logic                    rsp_stopped
);

   // an abort always lands in idle with the setpoint cleared
   `RPS_ASSERT_NOW(a_stop_clears, clock, reset, rsp_valid && rsp_stopped, (rsp_phase == PH_IDLE) && (rsp_setpoint == '0), "stop without idle and zero setpoint")

   `RPS_ASSERT_NOW(a_stop_acted, clock, reset, rsp_valid && rsp_stopped, rsp_acted, "stop flagged on an item that was not acted on")

   // back-pressure reaches the input only with a result waiting
   `RPS_ASSERT_NOW(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled with no stalled result")

   // two consecutive results cannot both be stops
   `RPS_ASSERT_NEXT(a_single_stop, clock, reset, rsp_valid && !rsp_stall && rsp_stopped, !(rsp_valid && rsp_stopped && $past(rsp_valid && rsp_stopped)) || $past(rsp_stall), "stop repeated on back-to-back results")

   `RPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_phase) && $stable(rsp_setpoint), "stalled result changed")

endmodule

bind reflow_profile_sequencer rps_checker u_rps_checker (.*);

>>> dv/rps_profile_checker.sv
`timescale 1ns / 1ps
// checker for the reflow profile sequencer: follows the register port and the input items,
// predicts the phase, setpoint and flags of each result item and compares them
// depends on rps_pkg

module rps_profile_checker
   import rps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [TempW-1:0] req_temperature,
   input  logic                    req_run,
   input  logic [MsW-1:0]          req_now_ms,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [PhaseW-1:0]       rsp_phase,
   input  logic [LevelW-1:0]       rsp_setpoint,
   input  logic                    rsp_acted,
   input  logic                    rsp_stopped,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [AddrW-1:0]        csr_paddr,
   input  logic [DataW-1:0]        csr_pwdata,
   input  logic [DataW-1:0]        csr_prdata,
   input  logic                    csr_pready,
   output int                      errors,
   output int                      pending
);

   logic [LevelW-1:0] preheat_end;
   logic [SecW-1:0]   soak_sec;
   logic [LevelW-1:0] peak_temp;
   logic [SecW-1:0]   peak_sec;
   logic [LevelW-1:0] cool_temp;

   phase_type         cur_phase;
   logic [LevelW-1:0] level;
   logic [MsW-1:0]    phase_start_ms;
   logic              was_running;

   result_type        predicted_steps[$];
   int                error_tally = 0;
   int                due_count = 0;

   assign errors  = error_tally;
   assign pending = due_count;

   function automatic logic [DataW-1:0] reg_value(input logic [2:0] index);
      case (index)
         REG_SOAK_TEMP: return DataW'(preheat_end);
         REG_SOAK_SEC:  return DataW'(soak_sec);
         REG_PEAK_TEMP: return DataW'(peak_temp);
         REG_PEAK_SEC:  return DataW'(peak_sec);
         REG_COOL_TEMP: return DataW'(cool_temp);
         default:       return '0;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [DataW-1:0] want,
                              input logic [DataW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_tally++;
      end
   endtask

   // one control sample through the phase sequence
   task automatic step_profile(input item_type smp, output result_type res);
      int             temp;
      logic [MsW-1:0] elapsed;
      logic           acted;
      logic           stopped;
      temp    = smp.temperature;
      elapsed = smp.now_ms - phase_start_ms;
      acted   = 1'b0;
      stopped = 1'b0;
      if (smp.run) begin
         case (cur_phase)
            PH_IDLE: cur_phase = PH_PREHEAT;
            PH_PREHEAT: begin
               level = preheat_end;
               if (temp >= int'(preheat_end)) begin
                  phase_start_ms = smp.now_ms;
                  cur_phase      = PH_SOAK;
               end
            end
            PH_SOAK: begin
               level = preheat_end;
               if (elapsed >= MsW'(soak_sec) * MsW'(MS_PER_S)) begin
                  phase_start_ms = '0;
                  cur_phase      = PH_RAMP;
               end
            end
            PH_RAMP: begin
               level = peak_temp;
               if (temp >= int'(peak_temp)) begin
                  phase_start_ms = smp.now_ms;
                  cur_phase      = PH_REFLOW;
               end
            end
            PH_REFLOW: begin
               level = peak_temp;
               if (elapsed >= MsW'(peak_sec) * MsW'(MS_PER_S)) begin
                  phase_start_ms = '0;
                  cur_phase      = PH_COOL;
               end
            end
            PH_COOL: begin
               level = cool_temp;
               if (temp <= int'(cool_temp)) cur_phase = PH_IDLE;
            end
            default: ;
         endcase
         was_running = 1'b1;
         acted       = 1'b1;
      end else if (was_running) begin
         // first low run after activity aborts to idle
         cur_phase   = PH_IDLE;
         level       = '0;
         was_running = 1'b0;
         acted       = 1'b1;
         stopped     = 1'b1;
      end
      res.phase    = cur_phase;
      res.setpoint = level;
      res.acted    = acted;
      res.stopped  = stopped;
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      item_type   smp;
      logic [2:0] index;
      if (reset) begin
         preheat_end    = RST_SOAK_TEMP;
         soak_sec       = RST_SOAK_SEC;
         peak_temp      = RST_PEAK_TEMP;
         peak_sec       = RST_PEAK_SEC;
         cool_temp      = RST_COOL_TEMP;
         cur_phase      = PH_IDLE;
         level          = '0;
         phase_start_ms = '0;
         was_running    = 1'b1;
         predicted_steps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.phase    = rsp_phase;
            seen.setpoint = rsp_setpoint;
            seen.acted    = rsp_acted;
            seen.stopped  = rsp_stopped;
            if (predicted_steps.size() == 0) begin
               $display("%0t: result item with nothing expected, expected none, actual %h",
                        $time, seen);
               error_tally++;
            end else begin
               want = predicted_steps.pop_front();
               check_field("phase", DataW'(want.phase), DataW'(seen.phase));
               check_field("setpoint", DataW'(want.setpoint), DataW'(seen.setpoint));
               check_field("acted", DataW'(want.acted), DataW'(seen.acted));
               check_field("stopped", DataW'(want.stopped), DataW'(seen.stopped));
            end
         end
         if (req_valid && !req_stall) begin
            smp.temperature = req_temperature;
            smp.run         = req_run;
            smp.now_ms      = req_now_ms;
            step_profile(smp, want);
            predicted_steps.push_back(want);
         end
         if (csr_psel && csr_penable && csr_pready) begin
            index = csr_paddr[AddrW-1:2];
            if (csr_pwrite) begin
               case (index)
                  REG_SOAK_TEMP: preheat_end = csr_pwdata[LevelW-1:0];
                  REG_SOAK_SEC:  soak_sec    = csr_pwdata[SecW-1:0];
                  REG_PEAK_TEMP: peak_temp   = csr_pwdata[LevelW-1:0];
                  REG_PEAK_SEC:  peak_sec    = csr_pwdata[SecW-1:0];
                  REG_COOL_TEMP: cool_temp   = csr_pwdata[LevelW-1:0];
                  default: ;
               endcase
            end else if (index <= REG_COOL_TEMP) begin
               check_field("register readback", reg_value(index), csr_prdata);
            end
         end
      end
      due_count <= predicted_steps.size();
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// top of the reflow profile sequencer testbench: clock, reset, sample and register stimulus,
// receiver stalls and the verdict; depends on rps_pkg, reflow_profile_sequencer, rps_profile_checker

module testbench;
   import rps_pkg::*;

   localparam int ITEMS_PER_SETTING = 305;
   localparam int HOLD_CYCLES       = 300;
   localparam int QUIET_LIMIT       = 4000;
   localparam int SETTLE_CYCLES     = 4;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURST} stall_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [TempW-1:0] req_temperature = '0;
   logic                    req_run = 1'b0;
   logic [MsW-1:0]          req_now_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PhaseW-1:0]       rsp_phase;
   logic [LevelW-1:0]       rsp_setpoint;
   logic                    rsp_acted;
   logic                    rsp_stopped;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [AddrW-1:0]        csr_paddr = '0;
   logic [DataW-1:0]        csr_pwdata = '0;
   logic [DataW-1:0]        csr_prdata;
   logic                    csr_pready;

   int errors;
   int pending;

   // steering copies of the registers, used only to aim the stimulus
   int preheat_end_now = RST_SOAK_TEMP;
   int soak_sec_now    = RST_SOAK_SEC;
   int peak_temp_now   = RST_PEAK_TEMP;
   int peak_sec_now    = RST_PEAK_SEC;
   int cool_temp_now   = RST_COOL_TEMP;

   logic [MsW-1:0] stamp_ms = '0;
   int             burst_left = 0;
   int             sent_count = 0;
   int             setting_count = 0;
   int             hold_requests = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   reflow_profile_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_temperature(req_temperature), .req_run(req_run), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_phase(rsp_phase), .rsp_setpoint(rsp_setpoint),
      .rsp_acted(rsp_acted), .rsp_stopped(rsp_stopped),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   rps_profile_checker profile_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_temperature(req_temperature), .req_run(req_run), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_phase(rsp_phase), .rsp_setpoint(rsp_setpoint),
      .rsp_acted(rsp_acted), .rsp_stopped(rsp_stopped),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .errors(errors), .pending(pending)
   );

   // receiver: long hold-offs on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
            default:     rsp_stall <= ((mode_left % 11) < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_item(input int temp, input logic run, input logic [MsW-1:0] now_ms);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid       <= 1'b1;
      req_temperature <= TempW'(temp);
      req_run         <= run;
      req_now_ms      <= now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent_count++;
   endtask

   task automatic csr_access(input logic write, input logic [2:0] index,
                             input logic [DataW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= AddrW'({index, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // lets every result drain before the registers are touched
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [DataW-1:0] st, input logic [DataW-1:0] ss,
                                input logic [DataW-1:0] pt, input logic [DataW-1:0] ps,
                                input logic [DataW-1:0] ct);
      csr_access(1'b1, REG_SOAK_TEMP, st);
      csr_access(1'b1, REG_SOAK_SEC, ss);
      csr_access(1'b1, REG_PEAK_TEMP, pt);
      csr_access(1'b1, REG_PEAK_SEC, ps);
      csr_access(1'b1, REG_COOL_TEMP, ct);
      // writes past the last register must leave everything alone
      for (int i = REG_COOL_TEMP + 1; i < 8; i++) csr_access(1'b1, 3'(i), $urandom());
      for (int i = REG_SOAK_TEMP; i <= REG_COOL_TEMP; i++) csr_access(1'b0, 3'(i), '0);
      preheat_end_now = int'(st[LevelW-1:0]);
      soak_sec_now    = int'(ss[SecW-1:0]);
      peak_temp_now   = int'(pt[LevelW-1:0]);
      peak_sec_now    = int'(ps[SecW-1:0]);
      cool_temp_now   = int'(ct[LevelW-1:0]);
      setting_count++;
   endtask

   // temperatures cluster round the thresholds so the phases keep moving
   function automatic int pick_temperature();
      int t;
      case ($urandom_range(0, 9))
         0, 1: t = int'($urandom_range(0, 1279)) - 256;
         2:    t = preheat_end_now + int'($urandom_range(0, 4)) - 2;
         3:    t = peak_temp_now + int'($urandom_range(0, 4)) - 2;
         4:    t = cool_temp_now + int'($urandom_range(0, 4)) - 2;
         5:    t = 1023 - int'($urandom_range(0, 3));
         6:    t = int'($urandom_range(0, 56)) - 256;
         default: t = int'($urandom_range(cool_temp_now, peak_temp_now + 3));
      endcase
      if (t < -256) t = -256;
      if (t > 1023) t = 1023;
      return t;
   endfunction

   function automatic logic [MsW-1:0] pick_step();
      int unsigned span;
      span = (soak_sec_now > peak_sec_now ? soak_sec_now : peak_sec_now) * MS_PER_S;
      if (span < MS_PER_S) span = MS_PER_S;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return $urandom();
         2, 3:    return $urandom_range(span / 2, span + 2);
         default: return $urandom_range(0, span / 3);
      endcase
   endfunction

   task automatic run_samples(input int count, input logic hold_off);
      int low_left;
      low_left = 0;
      stamp_ms = $urandom();
      for (int n = 0; n < count; n++) begin
         logic run_level;
         if (low_left == 0 && $urandom_range(0, 29) == 0) low_left = $urandom_range(1, 3);
         run_level = (low_left == 0);
         if (low_left > 0) low_left--;
         stamp_ms += pick_step();
         if (hold_off && n == count / 2) hold_requests++;
         send_item(pick_temperature(), run_level, stamp_ms);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset values read back before anything is written
      for (int i = REG_SOAK_TEMP; i <= REG_COOL_TEMP; i++) csr_access(1'b0, 3'(i), '0);

      // one full profile under the reset settings, with wrap-around timestamps
      send_item(25, 1'b0, 32'd0);
      send_item(25, 1'b0, 32'd0);
      send_item(-256, 1'b1, 32'd100);
      send_item(-256, 1'b1, 32'd200);
      send_item(149, 1'b1, 32'd300);
      send_item(150, 1'b1, 32'hFFFF_F000);
      send_item(1023, 1'b1, 32'hFFFF_F000 + 32'd89999);
      send_item(0, 1'b1, 32'hFFFF_F000 + 32'd90000);
      send_item(239, 1'b1, 32'd5);
      send_item(240, 1'b1, 32'hFFFF_FFFF);
      send_item(-1, 1'b1, 32'hFFFF_FFFF + 32'd59999);
      send_item(1023, 1'b1, 32'hFFFF_FFFF + 32'd60000);
      send_item(51, 1'b1, 32'd70000);
      send_item(50, 1'b1, 32'd70001);
      send_item(1023, 1'b1, 32'd70002);
      send_item(1023, 1'b0, 32'hFFFF_FFFF);
      send_item(1023, 1'b0, 32'd0);
      send_item(-1, 1'b1, 32'hAAAA_5555);
      send_item(-1, 1'b1, 32'h5555_AAAA);
      send_item(1023, 1'b0, 32'd0);
      run_samples(ITEMS_PER_SETTING, 1'b0);
      settle();

      // raw words, so the upper bits must be dropped
      apply_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      run_samples(ITEMS_PER_SETTING, 1'b1);
      settle();

      apply_setting('0, '0, '0, '0, '0);
      run_samples(ITEMS_PER_SETTING, 1'b0);
      settle();

      apply_setting(DataW'({LevelW{1'b1}}), DataW'({SecW{1'b1}}), DataW'({LevelW{1'b1}}),
                    DataW'({SecW{1'b1}}), DataW'({LevelW{1'b1}}));
      run_samples(ITEMS_PER_SETTING, 1'b1);
      settle();

      apply_setting($urandom_range(0, 1023), $urandom_range(0, 4095), $urandom_range(0, 1023),
                    $urandom_range(0, 4095), $urandom_range(0, 1023));
      run_samples(ITEMS_PER_SETTING, 1'b0);
      settle();

      // a realistic solder profile with short dwell times
      apply_setting($urandom_range(140, 200), $urandom_range(1, 120), $urandom_range(210, 260),
                    $urandom_range(1, 90), $urandom_range(25, 60));
      run_samples(ITEMS_PER_SETTING, 1'b1);
      settle();

      $display("sequencer run: %0d samples over %0d written register settings plus reset values",
               sent_count, setting_count);
      $display("%0d long receiver hold-offs, %0d mismatches", hold_requests, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
